/* rtl/i2c_master_byte_engine_macros.svh */
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// Concurrent assertion, quiet while reset is held.
`define I2CM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define I2CM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Field and counter widths
    localparam int unsigned I2CM_TIMER_W     = 16;
    localparam int unsigned I2CM_CFG_IDX_W   = 2;
    localparam int unsigned I2CM_CFG_DATA_W  = 16;
    localparam int unsigned I2CM_QUEUE_DEPTH = 2;

    localparam logic [I2CM_TIMER_W-1:0] I2CM_TIMER_MAX = '1;

    // Register reset values
    localparam logic [I2CM_TIMER_W-1:0] I2CM_HALF_PERIOD_RST   = 16'd2;
    localparam logic                    I2CM_STRETCH_EN_RST    = 1'b1;
    localparam logic [I2CM_TIMER_W-1:0] I2CM_STRETCH_LIMIT_RST = 16'd3000;

    // Configuration register indexes
    typedef enum logic [I2CM_CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD   = 2'd0,
        CFG_STRETCH_EN    = 2'd1,
        CFG_STRETCH_LIMIT = 2'd2
    } t_cfg_idx;

    // Command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Bus sequencer phases
    typedef enum logic [18:0] {
        PH_IDLE       = 19'h00001,
        PH_ST_SDA_REL = 19'h00002,
        PH_ST_SCL_REL = 19'h00004,
        PH_ST_SDA_LOW = 19'h00008,
        PH_ST_SCL_LOW = 19'h00010,
        PH_SP_SDA_LOW = 19'h00020,
        PH_SP_SCL_REL = 19'h00040,
        PH_SP_SDA_REL = 19'h00080,
        PH_WR_BIT     = 19'h00100,
        PH_WR_SCL_REL = 19'h00200,
        PH_WR_SCL_LOW = 19'h00400,
        PH_WR_SDA_REL = 19'h00800,
        PH_WR_ACK_SCL = 19'h01000,
        PH_RD_SDA_REL = 19'h02000,
        PH_RD_SCL_REL = 19'h04000,
        PH_RD_SCL_LOW = 19'h08000,
        PH_RD_GAP     = 19'h10000,
        PH_RD_ACK_SDA = 19'h20000,
        PH_RD_ACK_SCL = 19'h40000
    } t_phase;

    typedef struct packed {
        logic [I2CM_TIMER_W-1:0] half_period;
        logic                    stretch_en;
        logic [I2CM_TIMER_W-1:0] stretch_limit;
    } t_cfg;

    // One classified tick
    typedef struct packed {
        logic       has_cmd;
        t_cmd       cmd;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       scl_pin;
        logic       sda_pin;
    } t_item;

    // One result of a tick
    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic       stretch_timeout;
    } t_result;

endpackage

`default_nettype wire

/* rtl/i2cm_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front #(
    parameter int unsigned QUEUE_DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_cmd_valid,
    input  wire  [1:0]       i_mode,
    input  wire  [7:0]       i_write_byte,
    input  wire              i_send_ack,
    input  wire              i_scl_pin,
    input  wire              i_sda_pin,
    output logic             o_q_valid,
    output i2cm_pkg::t_item  o_q_item,
    input  wire              i_q_pop
);
    import i2cm_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_item            w_item;
    logic             w_push;
    logic             w_pop;

    // Classify the incoming tick
    always_comb begin
        w_item.has_cmd    = i_cmd_valid;
        w_item.write_byte = i_write_byte;
        w_item.send_ack   = i_send_ack;
        w_item.scl_pin    = i_scl_pin;
        w_item.sda_pin    = i_sda_pin;
        unique case (i_mode)
            2'd0:    w_item.cmd = CMD_START;
            2'd1:    w_item.cmd = CMD_STOP;
            2'd2:    w_item.cmd = CMD_WRITE;
            default: w_item.cmd = CMD_READ;
        endcase
    end

    assign o_in_ready = (r_count != FULL_CNT);
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    // Queue pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2cm_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  i2cm_pkg::t_cfg     i_cfg,
    input  wire                i_q_valid,
    input  i2cm_pkg::t_item    i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output i2cm_pkg::t_result  o_res
);
    import i2cm_pkg::*;

    t_phase                  r_phase, n_phase;
    logic [2:0]              r_bit, n_bit;
    logic [7:0]              r_shift, n_shift;
    logic [I2CM_TIMER_W-1:0] r_pt, n_pt;
    logic [I2CM_TIMER_W-1:0] r_st, n_st;
    logic                    r_ack, n_ack;
    logic [7:0]              r_read, n_read;
    logic                    r_timeout, n_timeout;
    logic                    r_scl_low, n_scl_low;
    logic                    r_sda_low, n_sda_low;
    logic                    r_waiting, n_waiting;
    logic                    r_ack_req, n_ack_req;
    logic                    r_out_valid;
    t_result                 r_res, n_res;
    logic                    w_step;

    // Take a tick when the result slot is free or being emptied
    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign w_step      = o_q_pop;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // One tick of the bus sequencer
    always_comb begin
        logic                    v_go;
        t_phase                  v_tgt;
        logic                    v_done;
        logic [I2CM_TIMER_W-1:0] v_hp;
        logic [I2CM_TIMER_W-1:0] v_pt;
        logic [I2CM_TIMER_W-1:0] v_st;

        n_phase   = r_phase;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_pt      = r_pt;
        n_st      = r_st;
        n_ack     = r_ack;
        n_read    = r_read;
        n_timeout = r_timeout;
        n_scl_low = r_scl_low;
        n_sda_low = r_sda_low;
        n_waiting = r_waiting;
        n_ack_req = r_ack_req;
        v_go      = 1'b0;
        v_tgt     = PH_IDLE;
        v_done    = 1'b0;
        v_hp      = (i_cfg.half_period == '0) ? I2CM_TIMER_W'(1) : i_cfg.half_period;
        v_pt      = (r_pt != I2CM_TIMER_MAX) ? r_pt + I2CM_TIMER_W'(1) : r_pt;
        v_st      = (r_st != I2CM_TIMER_MAX) ? r_st + I2CM_TIMER_W'(1) : r_st;

        if (r_phase == PH_IDLE) begin
            // Launch a new command
            if (i_q_item.has_cmd) begin
                n_bit     = '0;
                n_shift   = (i_q_item.cmd == CMD_READ) ? 8'h00 : i_q_item.write_byte;
                n_ack_req = i_q_item.send_ack;
                v_go      = 1'b1;
                unique case (i_q_item.cmd)
                    CMD_START: v_tgt = PH_ST_SDA_REL;
                    CMD_STOP:  v_tgt = PH_SP_SDA_LOW;
                    CMD_WRITE: v_tgt = PH_WR_BIT;
                    CMD_READ:  v_tgt = PH_RD_SDA_REL;
                    default:   v_tgt = PH_RD_SDA_REL;
                endcase
            end
        end else if (r_waiting) begin
            // Clock stretch wait
            if (i_q_item.scl_pin) begin
                n_waiting = 1'b0;
            end else begin
                n_st = v_st;
                if (v_st >= i_cfg.stretch_limit) begin
                    n_timeout = 1'b1;
                    n_waiting = 1'b0;
                end
            end
        end else begin
            // Hold count, then move to the next line action
            n_pt = v_pt;
            if (v_pt >= v_hp) begin
                v_go = 1'b1;
                unique case (r_phase)
                    PH_ST_SDA_REL: v_tgt = PH_ST_SCL_REL;
                    PH_ST_SCL_REL: v_tgt = PH_ST_SDA_LOW;
                    PH_ST_SDA_LOW: v_tgt = PH_ST_SCL_LOW;
                    PH_SP_SDA_LOW: v_tgt = PH_SP_SCL_REL;
                    PH_SP_SCL_REL: v_tgt = PH_SP_SDA_REL;
                    PH_WR_BIT:     v_tgt = PH_WR_SCL_REL;
                    PH_WR_SCL_REL: begin
                        if (r_bit != 3'd7) begin
                            n_bit     = r_bit + 3'd1;
                            n_shift   = {r_shift[6:0], 1'b0};
                            n_scl_low = 1'b1;
                            v_tgt     = PH_WR_BIT;
                        end else begin
                            v_tgt = PH_WR_SCL_LOW;
                        end
                    end
                    PH_WR_SCL_LOW: v_tgt = PH_WR_SDA_REL;
                    PH_WR_SDA_REL: v_tgt = PH_WR_ACK_SCL;
                    PH_WR_ACK_SCL: begin
                        n_ack     = i_q_item.sda_pin;
                        n_scl_low = 1'b1;
                        v_go      = 1'b0;
                        v_done    = 1'b1;
                    end
                    PH_RD_SDA_REL: v_tgt = PH_RD_SCL_REL;
                    PH_RD_SCL_REL: begin
                        n_shift = {r_shift[6:0], i_q_item.sda_pin};
                        v_tgt   = PH_RD_SCL_LOW;
                    end
                    PH_RD_SCL_LOW: begin
                        if (r_bit != 3'd7) begin
                            n_bit = r_bit + 3'd1;
                            v_tgt = PH_RD_SCL_REL;
                        end else begin
                            n_read = r_shift;
                            v_tgt  = PH_RD_GAP;
                        end
                    end
                    PH_RD_GAP:     v_tgt = PH_RD_ACK_SDA;
                    PH_RD_ACK_SDA: v_tgt = PH_RD_ACK_SCL;
                    PH_RD_ACK_SCL: begin
                        n_scl_low = 1'b1;
                        n_sda_low = 1'b0;
                        v_go      = 1'b0;
                        v_done    = 1'b1;
                    end
                    default: begin
                        // start and stop end with no extra line action
                        v_go   = 1'b0;
                        v_done = 1'b1;
                    end
                endcase
                if (v_done) begin
                    n_phase   = PH_IDLE;
                    n_pt      = '0;
                    n_waiting = 1'b0;
                end
            end
        end

        // Entry into a new phase and its line action
        if (v_go) begin
            n_phase   = v_tgt;
            n_pt      = '0;
            n_waiting = 1'b0;
            unique case (v_tgt)
                PH_ST_SDA_REL, PH_SP_SDA_REL, PH_WR_SDA_REL, PH_RD_SDA_REL: begin
                    n_sda_low = 1'b0;
                end
                PH_ST_SDA_LOW, PH_SP_SDA_LOW: begin
                    n_sda_low = 1'b1;
                end
                PH_ST_SCL_LOW, PH_WR_SCL_LOW, PH_RD_SCL_LOW: begin
                    n_scl_low = 1'b1;
                end
                PH_WR_BIT: begin
                    n_sda_low = ~n_shift[7];
                end
                PH_ST_SCL_REL, PH_SP_SCL_REL, PH_WR_SCL_REL,
                PH_WR_ACK_SCL, PH_RD_SCL_REL, PH_RD_ACK_SCL: begin
                    n_scl_low = 1'b0;
                    n_timeout = 1'b0;
                    n_st      = '0;
                    n_waiting = i_cfg.stretch_en;
                end
                PH_RD_ACK_SDA: begin
                    n_sda_low = n_ack_req;
                end
                default: begin
                end
            endcase
        end

        n_res.scl_pull_low    = n_scl_low;
        n_res.sda_pull_low    = n_sda_low;
        n_res.busy            = (n_phase != PH_IDLE);
        n_res.done            = v_done;
        n_res.read_byte       = n_read;
        n_res.ack_seen        = n_ack;
        n_res.stretch_timeout = n_timeout;
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit     <= '0;
            r_shift   <= '0;
            r_pt      <= '0;
            r_st      <= '0;
            r_ack     <= 1'b1;
            r_read    <= '0;
            r_timeout <= 1'b0;
            r_scl_low <= 1'b0;
            r_sda_low <= 1'b0;
            r_waiting <= 1'b0;
            r_ack_req <= 1'b0;
        end else if (w_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_pt      <= n_pt;
            r_st      <= n_st;
            r_ack     <= n_ack;
            r_read    <= n_read;
            r_timeout <= n_timeout;
            r_scl_low <= n_scl_low;
            r_sda_low <= n_sda_low;
            r_waiting <= n_waiting;
            r_ack_req <= n_ack_req;
        end
    end

    // Result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

/* rtl/i2c_master_byte_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// I2C master byte engine for open-drain SCL/SDA. Every input transfer is one
// bus tick carrying the sampled pin levels and an optional command (start,
// stop, byte write with ACK sample, byte read with ACK/NACK); every tick gives
// exactly one result transfer with the line drives and status. The engine
// takes one tick per cycle unless a side stalls: a front stage decodes ticks
// into a short queue (depth QUEUE_DEPTH), the sequencer executes one tick per
// cycle while its result slot can take it and places the result in an output
// register, so a tick passes the queue, then that register. Either side may
// stall independently. Configuration writes (half period, stretch enable,
// stretch limit) take effect on the next cycle and belong between commands.
module i2c_master_byte_engine #(
    parameter int unsigned QUEUE_DEPTH = i2cm_pkg::I2CM_QUEUE_DEPTH
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [i2cm_pkg::I2CM_CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [i2cm_pkg::I2CM_CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire                                   i_cmd_valid,
    input  wire  [1:0]                            i_mode,
    input  wire  [7:0]                            i_write_byte,
    input  wire                                   i_send_ack,
    input  wire                                   i_scl_pin,
    input  wire                                   i_sda_pin,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_scl_pull_low,
    output logic                                  o_sda_pull_low,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [7:0]                            o_read_byte,
    output logic                                  o_ack_seen,
    output logic                                  o_stretch_timeout
);
    import i2cm_pkg::*;

    t_cfg    r_cfg;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_pop;
    t_result w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period   <= I2CM_HALF_PERIOD_RST;
            r_cfg.stretch_en    <= I2CM_STRETCH_EN_RST;
            r_cfg.stretch_limit <= I2CM_STRETCH_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HALF_PERIOD:   r_cfg.half_period   <= i_cfg_data[I2CM_TIMER_W-1:0];
                CFG_STRETCH_EN:    r_cfg.stretch_en    <= i_cfg_data[0];
                CFG_STRETCH_LIMIT: r_cfg.stretch_limit <= i_cfg_data[I2CM_TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd_valid  (i_cmd_valid),
        .i_mode       (i_mode),
        .i_write_byte (i_write_byte),
        .i_send_ack   (i_send_ack),
        .i_scl_pin    (i_scl_pin),
        .i_sda_pin    (i_sda_pin),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_res)
    );

    assign o_scl_pull_low    = w_res.scl_pull_low;
    assign o_sda_pull_low    = w_res.sda_pull_low;
    assign o_busy_res        = w_res.busy;
    assign o_done_res        = w_res.done;
    assign o_read_byte       = w_res.read_byte;
    assign o_ack_seen        = w_res.ack_seen;
    assign o_stretch_timeout = w_res.stretch_timeout;

endmodule

`default_nettype wire

/* rtl/i2cm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_byte_engine_macros.svh"

module i2cm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_in_ready,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire       o_scl_pull_low,
    input wire       o_sda_pull_low,
    input wire       o_busy_res,
    input wire       o_done_res,
    input wire [7:0] o_read_byte,
    input wire       o_ack_seen,
    input wire       o_stretch_timeout
);

    logic        w_stalled;
    logic [13:0] w_res;

    assign w_stalled = o_out_valid && !i_out_ready;
    assign w_res     = {o_scl_pull_low, o_sda_pull_low, o_busy_res, o_done_res,
                        o_read_byte, o_ack_seen, o_stretch_timeout};

    // Reset empties the result slot
    `I2CM_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Reset empties the queue, so the input side is open
    `I2CM_ASSERT_RST(a_rst_ready, !i_rst_n |=> o_in_ready, "input not ready after reset")

    // A completing tick leaves the engine idle
    `I2CM_ASSERT(a_done_idle, o_out_valid && o_done_res |-> !o_busy_res, "done while busy")

    // A stalled result holds its line drives and status
    `I2CM_ASSERT(a_stall_hold, w_stalled |=> o_out_valid && $stable(w_res), "stalled result moved")

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_scl_pull_low    (o_scl_pull_low),
    .o_sda_pull_low    (o_sda_pull_low),
    .o_busy_res        (o_busy_res),
    .o_done_res        (o_done_res),
    .o_read_byte       (o_read_byte),
    .o_ack_seen        (o_ack_seen),
    .o_stretch_timeout (o_stretch_timeout)
);

`default_nettype wire
